// ===== sv/fla_pkg.sv =====
// Shared types and constants for the free-list slot allocator.
// No dependencies; imported by fla_ram users and the top level.
`default_nettype none

package fla_pkg;

  localparam int SLOT_W         = 10;    // slot index field width
  localparam int CNT_W          = 11;    // count field width
  localparam int POOL_SLOTS_DEF = 1024;  // default pool size
  localparam int CHUNK_RESET    = 16;    // chunk size after reset
  localparam int TALLY_MAX      = 2047;  // free count ceiling

  localparam int IN_TDATA_W  = 16;       // slot_in, padded to bytes
  localparam int OUT_TDATA_W = 56;       // six result fields, padded to bytes

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LINK = 1'b1
  } state_t;

endpackage

`default_nettype wire

// ===== sv/free_list_slot_allocator.sv =====
// Free-list slot allocator top level: chunked pool growth, LIFO free list.
// Depends on fla_pkg and fla_ram (link memory).
//
//  channel | direction | transfer when          | contents
//  in_     | in        | in_tvalid & in_tready  | tuser: kind; tdata: slot_in
//  out_    | out       | out_tvalid & out_tready| tdata: slot_out, ok, counts
//  cfg_    | in        | cfg_wen                | cfg_wdata: chunk_slots
//
// A pop that leaves the list non-empty enters ST_LINK, which holds off input
// until the link read lands. The result is registered in the cycle after the
// transfer. Input is taken only while the output register is empty or drains
// in the same cycle, so an output stall holds the result and blocks input.
// Reset (synchronous, rst_n low) restores chunk_slots to 16 with one chunk open;
// a configuration write restarts the pool the same way. Link memory is not cleared.
`default_nettype none

module free_list_slot_allocator
#(
  parameter int POOL_SLOTS = fla_pkg::POOL_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [fla_pkg::IN_TDATA_W-1:0] in_tdata,   // [9:0] slot_in
  input  wire logic                           in_tuser,   // [0] kind
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [9:0] slot_out, [10] ok, [21:11] chunks_open, [32:22] total_slots,
  // [43:33] free_slots, [54:44] used_slots
  output logic [fla_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  wire logic                           cfg_wen,
  input  wire logic [fla_pkg::CNT_W-1:0]      cfg_wdata   // chunk_slots
);

  import fla_pkg::*;

  localparam int PW = $clog2(POOL_SLOTS + 1);
  localparam int CW = (PW > CNT_W) ? PW : CNT_W;
  localparam int AW = $clog2(POOL_SLOTS);

  function automatic logic [CW-1:0] clamp_chunk(input logic [CNT_W-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w == '0) begin
      w = CW'(1);
    end else if (w > CW'(POOL_SLOTS)) begin
      w = CW'(POOL_SLOTS);
    end
    return w;
  endfunction

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  chunk_slots_r;
  logic [SLOT_W-1:0] list_head_r, list_head_nxt;
  logic              list_empty_r, list_empty_nxt;
  logic [CW-1:0]     fresh_next_r, fresh_next_nxt;
  logic [CW-1:0]     chunk_limit_r, chunk_limit_nxt;
  logic [CW-1:0]     chunk_tally_r, chunk_tally_nxt;
  logic [CW-1:0]     free_tally_r, free_tally_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [CW-1:0]     cs, cfg_cs, fresh_left, depth, slot_ext, fr, used;
  logic [CW:0]       grow_sum;
  logic [SLOT_W-1:0] granted;
  logic              ok, accept, is_alloc;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [SLOT_W-1:0] rd_data;

  fla_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (POOL_SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (list_head_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cs         = clamp_chunk(chunk_slots_r);
  assign cfg_cs     = clamp_chunk(cfg_wdata);
  assign fresh_left = chunk_limit_r - fresh_next_r;
  assign depth      = free_tally_r - fresh_left;
  assign slot_ext   = CW'(in_tdata[SLOT_W-1:0]);
  assign grow_sum   = (CW+1)'(chunk_limit_r) + (CW+1)'(cs);
  assign wr_addr    = slot_ext[AW-1:0];
  assign rd_addr    = AW'(CW'(list_head_r));
  assign is_alloc   = (kind_t'(in_tuser) == KIND_ALLOC);

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt       = state_r;
    list_head_nxt   = list_head_r;
    list_empty_nxt  = list_empty_r;
    fresh_next_nxt  = fresh_next_r;
    chunk_limit_nxt = chunk_limit_r;
    chunk_tally_nxt = chunk_tally_r;
    free_tally_nxt  = free_tally_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    granted         = '0;
    ok              = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    fr              = '0;
    used            = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (out_valid_r && out_tready) begin
          out_valid_nxt = 1'b0;
        end
        if (accept) begin
          if (is_alloc) begin
            if (!list_empty_r) begin
              granted        = list_head_r;
              free_tally_nxt = free_tally_r - CW'(1);
              ok             = 1'b1;
              if (depth <= CW'(1)) begin
                list_empty_nxt = 1'b1;
              end else begin
                // fetch the link of the popped slot; head updates in ST_LINK
                rd_en     = 1'b1;
                state_nxt = ST_LINK;
              end
            end else if (fresh_next_r < chunk_limit_r) begin
              granted        = fresh_next_r[SLOT_W-1:0];
              fresh_next_nxt = fresh_next_r + CW'(1);
              free_tally_nxt = free_tally_r - CW'(1);
              ok             = 1'b1;
            end else if (grow_sum <= (CW+1)'(POOL_SLOTS)) begin
              // open a new chunk and take its first slot
              chunk_limit_nxt = grow_sum[CW-1:0];
              chunk_tally_nxt = chunk_tally_r + CW'(1);
              free_tally_nxt  = free_tally_r + cs - CW'(1);
              granted         = fresh_next_r[SLOT_W-1:0];
              fresh_next_nxt  = fresh_next_r + CW'(1);
              ok              = 1'b1;
            end
          end else if (slot_ext < chunk_limit_r && slot_ext < CW'(POOL_SLOTS) &&
                       free_tally_r < CW'(TALLY_MAX)) begin
            wr_en          = 1'b1;
            list_head_nxt  = in_tdata[SLOT_W-1:0];
            list_empty_nxt = 1'b0;
            free_tally_nxt = free_tally_r + CW'(1);
            ok             = 1'b1;
          end

          fr   = (free_tally_nxt < chunk_limit_nxt) ? free_tally_nxt : chunk_limit_nxt;
          used = chunk_limit_nxt - fr;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, used[CNT_W-1:0], fr[CNT_W-1:0],
                           chunk_limit_nxt[CNT_W-1:0], chunk_tally_nxt[CNT_W-1:0],
                           ok, (ok && is_alloc) ? granted : SLOT_W'(0)};
        end
      end
      ST_LINK: begin
        list_head_nxt = rd_data;
        state_nxt     = ST_IDLE;
        if (out_valid_r && out_tready) begin
          out_valid_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      chunk_slots_r <= CNT_W'(CHUNK_RESET);
      list_head_r   <= '0;
      list_empty_r  <= 1'b1;
      fresh_next_r  <= '0;
      chunk_limit_r <= clamp_chunk(CNT_W'(CHUNK_RESET));
      chunk_tally_r <= CW'(1);
      free_tally_r  <= clamp_chunk(CNT_W'(CHUNK_RESET));
      out_valid_r   <= 1'b0;
    end else if (cfg_wen) begin
      // restart with one chunk of the new size open
      state_r       <= ST_IDLE;
      chunk_slots_r <= cfg_wdata;
      list_head_r   <= '0;
      list_empty_r  <= 1'b1;
      fresh_next_r  <= '0;
      chunk_limit_r <= cfg_cs;
      chunk_tally_r <= CW'(1);
      free_tally_r  <= cfg_cs;
      out_valid_r   <= out_valid_nxt;
    end else begin
      state_r       <= state_nxt;
      list_head_r   <= list_head_nxt;
      list_empty_r  <= list_empty_nxt;
      fresh_next_r  <= fresh_next_nxt;
      chunk_limit_r <= chunk_limit_nxt;
      chunk_tally_r <= chunk_tally_nxt;
      free_tally_r  <= free_tally_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // link fetch state only follows an accepted pop
  a_link_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINK) |-> $past(accept && is_alloc && !list_empty_r))
    else $error("link fetch without a pop");

  a_fresh_in_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (fresh_next_r <= chunk_limit_r) && (chunk_limit_r <= CW'(POOL_SLOTS)))
    else $error("fresh pointer beyond opened chunks");

  a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
    list_empty_r |-> (depth == '0))
    else $error("empty free list with nonzero depth");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("link write and read in one cycle");

endmodule

`default_nettype wire

// ===== sv/fla_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fla_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
